// ===== rtl/hda_pkg.sv =====
`timescale 1ns / 1ps

package hda_pkg;

  // Largest geometry supported; the sum store is sized for the block size and block rows.
  localparam int MaxBlockSize = 4;
  localparam int MaxBlockRows = 64;
  localparam int MaxColumns   = 4096;

  // Field and store widths.
  localparam int SampleW = 32;
  localparam int SumW    = 40;
  localparam int SeqW    = 13;
  localparam int CompW   = 2;
  localparam int BRowW   = 6;
  localparam int ColW    = 12;
  localparam int CntW    = 7;
  localparam int AddrW   = 8;
  localparam int StoreDepth = MaxBlockRows * MaxBlockSize;

  // The restoring divider retires one quotient bit per step.
  localparam int DivSteps = SumW;
  localparam int DivCntW  = 6;

  // Register map, as word indexes.
  typedef enum logic [1:0] {
    RegBlockSize   = 2'd0,
    RegBlockRows   = 2'd1,
    RegColumnCount = 2'd2,
    RegUnused      = 2'd3
  } hda_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StAcc,
    StAbs,
    StDiv,
    StOut
  } hda_state_e;

  // Saturated geometry as held by the register file.
  typedef struct packed {
    logic [2:0]  block_size;
    logic [6:0]  block_rows;
    logic [12:0] column_count;
  } hda_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic read;
    logic acc;
    logic absv;
    logic step;
    logic load;
  } hda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_res;
    logic div_last;
  } hda_sts_t;

endpackage

// ===== rtl/block_hankel_diagonal_average.sv =====
`timescale 1ns / 1ps
// Result path: an element that closes a sequence component goes after its transfer
// through read, accumulate, magnitude, the divider steps and output load.
// A new element is taken only once the previous one is done, and the output load waits
// for a held result; the bit-serial restoring divider retires one quotient bit per cycle.
// Reset (asynchronous, active low) clears the matrix position, the control state and
// the geometry to one block of one row and one column; the sum store is not cleared.

module block_hankel_diagonal_average import hda_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] average_o,
  output logic [SeqW-1:0]           seq_index_o,
  output logic [CompW-1:0]          component_o,
  output logic                      is_last_o
);

  hda_cfg_t cfg;
  logic     cfg_wr;
  hda_cmd_t cmd;
  hda_sts_t sts;

  // Geometry registers.
  hda_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .cfg_wr_o (cfg_wr)
  );

  // Sequencing of each element.
  hda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Accumulation, division and output register.
  hda_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_wr_i    (cfg_wr),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (sample_i),
    .average_o   (average_o),
    .seq_index_o (seq_index_o),
    .component_o (component_o),
    .is_last_o   (is_last_o)
  );

endmodule

// ===== rtl/hda_regs.sv =====
`timescale 1ns / 1ps

module hda_regs import hda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output hda_cfg_t    cfg_o,
  output logic        cfg_wr_o
);

  hda_cfg_t cfg_q, cfg_d;
  hda_reg_e reg_sel;
  logic     wr_en;
  logic [2:0]  bs_in;
  logic [6:0]  br_in;
  logic [12:0] cc_in;

  assign pready  = 1'b1;
  assign reg_sel = hda_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign bs_in   = pwdata[2:0];
  assign br_in   = pwdata[6:0];
  assign cc_in   = pwdata[12:0];

  // Write decode with saturation into the supported geometry.
  always_comb begin
    cfg_d    = cfg_q;
    cfg_wr_o = 1'b0;
    if (wr_en) begin
      unique case (reg_sel)
        RegBlockSize: begin
          cfg_wr_o = 1'b1;
          if (bs_in == 3'd0) begin
            cfg_d.block_size = 3'd1;
          end else if (bs_in > 3'(MaxBlockSize)) begin
            cfg_d.block_size = 3'(MaxBlockSize);
          end else begin
            cfg_d.block_size = bs_in;
          end
        end
        RegBlockRows: begin
          cfg_wr_o = 1'b1;
          if (br_in == 7'd0) begin
            cfg_d.block_rows = 7'd1;
          end else if (br_in > 7'(MaxBlockRows)) begin
            cfg_d.block_rows = 7'(MaxBlockRows);
          end else begin
            cfg_d.block_rows = br_in;
          end
        end
        RegColumnCount: begin
          cfg_wr_o = 1'b1;
          if (cc_in == 13'd0) begin
            cfg_d.column_count = 13'd1;
          end else if (cc_in > 13'(MaxColumns)) begin
            cfg_d.column_count = 13'(MaxColumns);
          end else begin
            cfg_d.column_count = cc_in;
          end
        end
        default: begin
          cfg_wr_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{block_size: 3'd1, block_rows: 7'd1, column_count: 13'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_sel)
      RegBlockSize:   prdata = {29'd0, cfg_q.block_size};
      RegBlockRows:   prdata = {25'd0, cfg_q.block_rows};
      RegColumnCount: prdata = {19'd0, cfg_q.column_count};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/hda_ctrl.sv =====
`timescale 1ns / 1ps

module hda_ctrl import hda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output hda_cmd_t cmd_o,
  input  hda_sts_t sts_i
);

  hda_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands. The output register is freed by a transfer
  // and refilled from the divider in the output state.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StRead;
        end
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d    = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.final_res ? StAbs : StIdle;
      end
      StAbs: begin
        cmd_o.absv = 1'b1;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/hda_dpath.sv =====
`timescale 1ns / 1ps

module hda_dpath import hda_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hda_cfg_t                  cfg_i,
  input  logic                      cfg_wr_i,
  input  hda_cmd_t                  cmd_i,
  output hda_sts_t                  sts_o,
  input  logic signed [SampleW-1:0] sample_i,
  output logic signed [SampleW-1:0] average_o,
  output logic [SeqW-1:0]           seq_index_o,
  output logic [CompW-1:0]          component_o,
  output logic                      is_last_o
);

  // Matrix walk position.
  logic [CompW-1:0] k_q, k_d;
  logic [BRowW-1:0] i_q, i_d;
  logic [ColW-1:0]  j_q, j_d;
  logic             k_wrap, i_wrap, j_wrap, j_end, i_end;

  // Item held during its read-modify-write and division.
  logic [SampleW-1:0] sample_q;
  logic [AddrW-1:0]   addr_q;
  logic [SeqW-1:0]    seq_q;
  logic [CompW-1:0]   comp_q;
  logic               first_q, final_q, last_q;
  logic [CntW-1:0]    cnt_q;

  // Sum store and divider.
  logic [SumW-1:0]    mem [StoreDepth];
  logic [SumW-1:0]    rdata_q;
  logic [SumW-1:0]    sum;
  logic [SumW-1:0]    quo_q;
  logic [CntW-1:0]    rem_q;
  logic               neg_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [CntW:0]      trial;
  logic               qbit;

  // Contribution count terms.
  logic [SeqW-1:0] p_m1, nc_m1, tail, m_a, m_b, m_min;

  // Output register.
  logic [SampleW-1:0] average_q;
  logic [SeqW-1:0]    seq_out_q;
  logic [CompW-1:0]   comp_out_q;
  logic               last_out_q;

  // Position compare and advance.
  assign k_wrap = ({1'b0, k_q} == cfg_i.block_size - 3'd1);
  assign i_end  = ({1'b0, i_q} == cfg_i.block_rows - 7'd1);
  assign j_end  = ({1'b0, j_q} == cfg_i.column_count - 13'd1);
  assign i_wrap = k_wrap && i_end;
  assign j_wrap = i_wrap && j_end;

  always_comb begin
    k_d = k_q;
    i_d = i_q;
    j_d = j_q;
    if (cfg_wr_i) begin
      k_d = '0;
      i_d = '0;
      j_d = '0;
    end else if (cmd_i.accept) begin
      k_d = k_wrap ? '0 : k_q + 1'b1;
      if (k_wrap) begin
        i_d = i_end ? '0 : i_q + 1'b1;
      end
      if (i_wrap) begin
        j_d = j_end ? '0 : j_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
    end else begin
      k_q <= k_d;
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  // Capture the item and its position flags on a transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
      seq_q    <= SeqW'(i_q) + SeqW'(j_q);
      addr_q   <= {6'(i_q + j_q[BRowW-1:0]), k_q};
      comp_q   <= k_q;
      first_q  <= (j_q == '0) || i_end;
      final_q  <= j_end || (i_q == '0);
      last_q   <= j_end && i_end && k_wrap;
    end
  end

  // Contribution count min(s, p-1, nc-1, l-1-s) + 1, formed during the read.
  assign p_m1  = SeqW'(cfg_i.block_rows) - 13'd1;
  assign nc_m1 = cfg_i.column_count - 13'd1;
  assign tail  = SeqW'(cfg_i.block_rows) + cfg_i.column_count - 13'd2 - seq_q;
  assign m_a   = (seq_q < p_m1) ? seq_q : p_m1;
  assign m_b   = (nc_m1 < tail) ? nc_m1 : tail;
  assign m_min = (m_a < m_b) ? m_a : m_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      cnt_q <= m_min[CntW-1:0] + 7'd1;
    end
  end

  // Sum store: registered read, then write back of the updated sum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rdata_q <= mem[addr_q];
    end
  end

  assign sum = first_q ? SumW'(signed'(sample_q))
                       : rdata_q + SumW'(signed'(sample_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      mem[addr_q] <= sum;
    end
  end

  // Restoring divider on the magnitude, one quotient bit per step.
  assign trial = {rem_q, quo_q[SumW-1]};
  assign qbit  = (trial >= {1'b0, cnt_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      quo_q <= sum;
    end else if (cmd_i.absv) begin
      neg_q     <= quo_q[SumW-1];
      quo_q     <= quo_q[SumW-1] ? -quo_q : quo_q;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.step) begin
      rem_q     <= qbit ? CntW'(trial - {1'b0, cnt_q}) : trial[CntW-1:0];
      quo_q     <= {quo_q[SumW-2:0], qbit};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  assign sts_o.final_res = final_q;
  assign sts_o.div_last  = (div_cnt_q == DivCntW'(DivSteps - 1));

  // Output register, with the sign restored.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      average_q  <= neg_q ? -quo_q[SampleW-1:0] : quo_q[SampleW-1:0];
      seq_out_q  <= seq_q;
      comp_out_q <= comp_q;
      last_out_q <= last_q;
    end
  end

  assign average_o   = signed'(average_q);
  assign seq_index_o = seq_out_q;
  assign component_o = comp_out_q;
  assign is_last_o   = last_out_q;

endmodule

// ===== rtl/hda_checker.sv =====
`timescale 1ns / 1ps

module hda_checker import hda_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [SampleW-1:0] average_o,
  input logic [SeqW-1:0]           seq_index_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(average_o)
      && $stable(seq_index_o))
    else $error("stalled result changed");

  // One element is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("element taken while another is in work");

  // A new result only appears after the block has stopped taking elements.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a division");

endmodule

bind block_hankel_diagonal_average hda_checker u_hda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .average_o   (average_o),
  .seq_index_o (seq_index_o)
);
